[design/epipolar_residual_inlier_score_defines.svh]
// Assertion macros for the epipolar residual scorer.
`ifndef EPIPOLAR_RESIDUAL_INLIER_SCORE_DEFINES_SVH
`define EPIPOLAR_RESIDUAL_INLIER_SCORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define ERIS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ERIS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ERIS_ASSERT(label, clk, rstn, prop, msg)
`define ERIS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

[design/eris_pkg.sv]
package eris_pkg;
    localparam int CoordW = 20;
    localparam int CoefW = 20;
    localparam int RowW = 60;
    localparam int ThrW = 24;
    localparam int ScoreW = 63;
    localparam int LineW = 42;
    localparam int NormBits = 30;
    localparam int ProdW = 52;
    localparam int N2W = 64;
    localparam int RootW = 32;
    localparam int DivW = 64;
    localparam logic [ThrW-1:0] ThrReset = 24'd145962;
    localparam logic [ScoreW-1:0] ScoreMax = {ScoreW{1'b1}};
    localparam logic [1:0] RegRow0 = 2'd0;
    localparam logic [1:0] RegRow1 = 2'd1;
    localparam logic [1:0] RegRow2 = 2'd2;
    localparam logic [1:0] RegThr = 2'd3;
    localparam int QDepth = 2;
    localparam int QPtrW = 1;

    typedef struct packed {
        logic signed [CoordW-1:0] first_x;
        logic signed [CoordW-1:0] first_y;
        logic signed [CoordW-1:0] second_x;
        logic signed [CoordW-1:0] second_y;
        logic                     final_pair;
    } pair_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } q_ctl_t;
endpackage

[design/epipolar_residual_inlier_score.sv]
// A pair that passes both tests is an inlier; it goes to the output early when the
// first line is zero or when either test fails. Each test runs a 32-step square root
// and, unless the root is zero, a 64-step divide. A new pair leaves the two-entry queue
// only after the last result is loaded; the queue takes beats meanwhile.
// Reset (aresetn low, synchronous): matrix zero, threshold 145962, score zero.
`include "epipolar_residual_inlier_score_defines.svh"
module epipolar_residual_inlier_score import eris_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic signed [CoordW-1:0] s_first_x,
    input  logic signed [CoordW-1:0] s_first_y,
    input  logic signed [CoordW-1:0] s_second_x,
    input  logic signed [CoordW-1:0] s_second_y,
    input  logic s_final_pair,
    output logic m_valid,
    input  logic m_ready,
    output logic m_is_inlier,
    output logic [ScoreW-1:0] m_running_score,
    output logic m_final_result,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [RowW-1:0] cfg_data
);
    logic [RowW-1:0] row0_reg, row1_reg, row2_reg;
    logic [ThrW-1:0] thr_reg;
    pair_t in_pair, q_pair;
    q_ctl_t q_ctl;
    logic q_take, busy;

    assign cfg_ready = 1'b1;
    assign in_pair = '{s_first_x, s_first_y, s_second_x, s_second_y, s_final_pair};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row0_reg <= '0;
            row1_reg <= '0;
            row2_reg <= '0;
            thr_reg <= ThrReset;
        end else if (cfg_valid) begin
            case (cfg_index)
                RegRow0: row0_reg <= cfg_data;
                RegRow1: row1_reg <= cfg_data;
                RegRow2: row2_reg <= cfg_data;
                RegThr:  thr_reg <= cfg_data[ThrW-1:0];
                default: ;
            endcase
        end
    end

    eris_front u_front (
        .aclk, .aresetn,
        .in_valid(s_valid), .in_ready(s_ready), .in_pair,
        .q_ctl, .q_pair, .q_take
    );

    eris_back u_back (
        .aclk, .aresetn,
        .row0(row0_reg), .row1(row1_reg), .row2(row2_reg), .thr(thr_reg),
        .q_ctl, .q_pair, .q_take, .busy,
        .m_valid, .m_ready, .m_is_inlier, .m_running_score, .m_final_result
    );

    `ERIS_ASSERT(a_cfg_idle, aclk, aresetn,
                 cfg_valid |-> !busy && q_ctl.ready && !q_ctl.valid, "cfg while busy")
    `ERIS_ASSERT_NEXT(a_thr_hold, aclk, aresetn, !cfg_valid, $stable(thr_reg),
                      "threshold moved")
    `ERIS_ASSERT(a_score_known, aclk, aresetn, m_valid |-> !$isunknown(m_running_score),
                 "unknown score")
endmodule

[design/eris_front.sv]
module eris_front import eris_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  pair_t in_pair,
    output q_ctl_t q_ctl,
    output pair_t q_pair,
    input  logic  q_take
);
    pair_t mem_reg [QDepth];
    logic [QPtrW-1:0] wr_reg, rd_reg;
    logic [QPtrW:0] cnt_reg, cnt_next;
    logic push, pop;

    assign in_ready = (cnt_reg != (QPtrW+1)'(QDepth));
    assign push = in_valid && in_ready;
    assign pop = q_take && (cnt_reg != '0);
    assign q_ctl.valid = (cnt_reg != '0);
    assign q_ctl.ready = in_ready;
    assign q_pair = mem_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 1'b1;
        else if (pop && !push) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
        end
        if (push) mem_reg[wr_reg] <= in_pair;
    end
endmodule

[design/eris_back.sv]
`include "epipolar_residual_inlier_score_defines.svh"
module eris_back import eris_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic [RowW-1:0] row0,
    input  logic [RowW-1:0] row1,
    input  logic [RowW-1:0] row2,
    input  logic [ThrW-1:0] thr,
    input  q_ctl_t q_ctl,
    input  pair_t  q_pair,
    output logic   q_take,
    output logic   busy,
    output logic   m_valid,
    input  logic   m_ready,
    output logic   m_is_inlier,
    output logic [ScoreW-1:0] m_running_score,
    output logic   m_final_result
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LINE = 4'd1;
    localparam logic [3:0] S_NORM = 4'd2;
    localparam logic [3:0] S_DOT  = 4'd3;
    localparam logic [3:0] S_SUM  = 4'd4;
    localparam logic [3:0] S_SQRT = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_SQ   = 4'd7;
    localparam logic [3:0] S_ACC  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;
    localparam logic [3:0] S_PROD = 4'd10;

    logic [3:0] st_reg;
    logic [1:0] k_reg;
    logic pass_reg;
    pair_t p_reg;
    logic signed [LineW-1:0] l_reg [3];
    logic signed [NormBits+1:0] s_reg [3];
    logic signed [ProdW-1:0] pr_reg [3];
    logic signed [ProdW+1:0] d_reg;
    logic [N2W-1:0] sq_reg [3];
    logic [N2W-1:0] n2_reg, rem_reg;
    logic [RootW-1:0] res_reg;
    logic [5:0] it_reg;
    logic [DivW-1:0] num_reg, dr_reg;
    logic [ThrW-1:0] mrg_reg;
    logic [2*ThrW-1:0] msq_reg;
    logic [ScoreW-1:0] acc_reg;
    logic out_v_reg, out_in_reg, out_fin_reg;
    logic [ScoreW-1:0] out_sc_reg;

    logic signed [CoefW-1:0] e [3][3];
    logic signed [CoordW:0] xa [3], xb [3];
    logic [LineW-1:0] mag [3];
    logic [LineW-1:0] mx;
    logic [5:0] nb;
    logic signed [NormBits+1:0] s [3];
    logic [N2W-1:0] trial;
    logic [DivW-1:0] dtrial;
    logic [ScoreW:0] accsum;
    logic [ThrW:0] mdiff;
    logic out_load;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e[0][i] = row0[i*CoefW +: CoefW];
            e[1][i] = row1[i*CoefW +: CoefW];
            e[2][i] = row2[i*CoefW +: CoefW];
        end
        xa[0] = (CoordW+1)'(p_reg.first_x);
        xa[1] = (CoordW+1)'(p_reg.first_y);
        xa[2] = (CoordW+1)'(65536);
        xb[0] = (CoordW+1)'(p_reg.second_x);
        xb[1] = (CoordW+1)'(p_reg.second_y);
        xb[2] = (CoordW+1)'(65536);
        mx = '0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = l_reg[i][LineW-1] ? LineW'(-l_reg[i]) : LineW'(l_reg[i]);
            if (mag[i] > mx) mx = mag[i];
        end
        nb = '0;
        for (int b = 0; b < LineW; b++) if (mx[b]) nb = 6'(b + 1);
        for (int i = 0; i < 3; i++) begin
            logic [LineW-1:0] v;
            v = (nb > 6'(NormBits)) ? (mag[i] >> (nb - 6'(NormBits)))
                                     : (mag[i] << (6'(NormBits) - nb));
            s[i] = l_reg[i][LineW-1] ? -$signed({2'b00, v[NormBits-1:0]})
                                      : $signed({2'b00, v[NormBits-1:0]});
        end
        trial = {rem_reg[N2W-3:0], n2_reg[N2W-1:N2W-2]};
        dtrial = {dr_reg[DivW-2:0], num_reg[DivW-1]};
        accsum = {1'b0, acc_reg} + {{(ScoreW+1-2*ThrW){1'b0}}, msq_reg};
        mdiff = {1'b0, thr} - {1'b0, num_reg[ThrW-1:0]};
    end

    assign q_take = (st_reg == S_IDLE) && q_ctl.valid;
    assign busy = (st_reg != S_IDLE) || out_v_reg;
    assign out_load = (st_reg == S_OUT) && (!out_v_reg || m_ready);
    assign m_valid = out_v_reg;
    assign m_is_inlier = out_in_reg;
    assign m_running_score = out_sc_reg;
    assign m_final_result = out_fin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            acc_reg <= '0;
            out_v_reg <= 1'b0;
        end else begin
            if (out_load) out_v_reg <= 1'b1;
            else if (m_ready) out_v_reg <= 1'b0;
            case (st_reg)
                S_IDLE: if (q_take) begin
                    p_reg <= q_pair;
                    k_reg <= '0;
                    pass_reg <= 1'b0;
                    st_reg <= S_LINE;
                end
                S_LINE: begin
                    for (int i = 0; i < 3; i++)
                        l_reg[i] <= (k_reg == '0)
                            ? LineW'(e[i][0]*xa[0] + e[i][1]*xa[1] + e[i][2]*xa[2])
                            : LineW'(e[0][i]*xb[0] + e[1][i]*xb[1] + e[2][i]*xb[2]);
                    st_reg <= S_NORM;
                end
                S_NORM: begin
                    if (mx == '0) st_reg <= S_OUT;
                    else begin
                        for (int i = 0; i < 3; i++) s_reg[i] <= s[i];
                        st_reg <= S_PROD;
                    end
                end
                S_PROD: begin
                    for (int i = 0; i < 3; i++) begin
                        pr_reg[i] <= ProdW'(s_reg[i] * ((k_reg == '0) ? xb[i] : xa[i]));
                        sq_reg[i] <= N2W'(s_reg[i] * s_reg[i]);
                    end
                    st_reg <= S_DOT;
                end
                S_DOT: begin
                    d_reg <= (ProdW+2)'(pr_reg[0]) + (ProdW+2)'(pr_reg[1])
                           + (ProdW+2)'(pr_reg[2]);
                    n2_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
                    st_reg <= S_SUM;
                end
                S_SUM: begin
                    rem_reg <= '0;
                    res_reg <= '0;
                    it_reg <= '0;
                    num_reg <= DivW'(d_reg[ProdW+1] ? -d_reg : d_reg) << 8;
                    st_reg <= S_SQRT;
                end
                S_SQRT: begin
                    if (trial >= {res_reg, 2'b01}) begin
                        rem_reg <= trial - {res_reg, 2'b01};
                        res_reg <= {res_reg[RootW-2:0], 1'b1};
                    end else begin
                        rem_reg <= trial;
                        res_reg <= {res_reg[RootW-2:0], 1'b0};
                    end
                    n2_reg <= {n2_reg[N2W-3:0], 2'b00};
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == 6'd31) begin
                        it_reg <= '0;
                        dr_reg <= '0;
                        st_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (res_reg == '0) st_reg <= S_OUT;
                    else begin
                        if (dtrial >= DivW'(res_reg)) begin
                            dr_reg <= dtrial - DivW'(res_reg);
                            num_reg <= {num_reg[DivW-2:0], 1'b1};
                        end else begin
                            dr_reg <= dtrial;
                            num_reg <= {num_reg[DivW-2:0], 1'b0};
                        end
                        it_reg <= it_reg + 1'b1;
                        if (it_reg == 6'd63) st_reg <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (num_reg[DivW-1:ThrW] != '0 || mdiff[ThrW]) st_reg <= S_OUT;
                    else begin
                        mrg_reg <= mdiff[ThrW-1:0];
                        st_reg <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (k_reg == '0) msq_reg <= mrg_reg * mrg_reg;
                    else msq_reg <= mrg_reg * mrg_reg;
                    k_reg <= k_reg + 2'd2;
                    if (k_reg[1]) begin
                        acc_reg <= accsum[ScoreW] ? ScoreMax : accsum[ScoreW-1:0];
                        k_reg <= 2'd1;
                        if (k_reg == 2'd3) begin
                            pass_reg <= 1'b1;
                            st_reg <= S_OUT;
                        end else st_reg <= S_LINE;
                    end
                end
                S_OUT: if (out_load) begin
                    out_in_reg <= pass_reg;
                    out_sc_reg <= acc_reg;
                    out_fin_reg <= p_reg.final_pair;
                    if (p_reg.final_pair) acc_reg <= '0;
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    `ERIS_ASSERT(a_take_idle, aclk, aresetn, q_take |-> q_ctl.valid, "take from empty queue")
    `ERIS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
                      m_valid && $stable(m_running_score), "result dropped")
    `ERIS_ASSERT_NEXT(a_final_clear, aclk, aresetn, out_load && p_reg.final_pair,
                      acc_reg == '0, "score not cleared")
endmodule
